FILE: design/cob_pkg.sv
// Shared constants, types and rounding helper for the contact basis core.
`timescale 1ns / 1ps

package cob_pkg;

   // Fixed-point format and reciprocal square root depth
   localparam int FRAC_BITS   = 14;
   localparam int RSQRT_ITERS = 3;
   localparam int COMP_W      = 16;

   // Scale exponent of tangent 1 before the per-item shift is taken off
   localparam int D_BASE = 45 - FRAC_BITS;

   // 3.0 in Q30 and the normalization floor 1.0 in Q30
   localparam logic [31:0] THREE_Q30 = 32'hC000_0000;
   localparam logic [63:0] ONE_Q30   = 64'h0000_0000_4000_0000;

   // Seeds of 1/sqrt(M) in Q16, indexed by the top three mantissa bits
   localparam logic [15:0] SEED_Q16 [8] = '{
      16'd58617, 16'd58617, 16'd58617, 16'd49541,
      16'd43691, 16'd39520, 16'd36353, 16'd33843
   };

   // Per-item context that rides along the pipeline
   typedef struct packed {
      logic signed [COMP_W-1:0] nx;
      logic signed [COMP_W-1:0] ny;
      logic signed [COMP_W-1:0] nz;
      logic                     use_x;
      logic                     deg;
   } ctx_type;

   // Shift right with rounding half away from zero, then saturate to 16 bits
   function automatic logic signed [COMP_W-1:0] rsat(input logic signed [63:0] v,
                                                     input logic [5:0] sh);
      logic [63:0]              mag;
      logic [63:0]              half;
      logic signed [COMP_W-1:0] res;
      half = (sh == 6'd0) ? 64'd0 : (64'd1 << (sh - 6'd1));
      mag  = v[63] ? 64'(-v) : 64'(v);
      mag  = (mag + half) >> sh;
      if (v[63]) begin
         res = (mag > 64'd32768) ? 16'sh8000 : 16'(64'd0 - mag);
      end else begin
         res = (mag > 64'd32767) ? 16'sh7FFF : mag[COMP_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: design/cob_req_if.sv
// Request channel: the contact normal.
`timescale 1ns / 1ps

interface cob_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   input ready);
   modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                   output ready);
endinterface

FILE: design/cob_rsp_if.sv
// Response channel: the orthonormal basis and degenerate flag.
`timescale 1ns / 1ps

interface cob_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] col0_x;
   logic signed [15:0] col0_y;
   logic signed [15:0] col0_z;
   logic signed [15:0] tan1_x;
   logic signed [15:0] tan1_y;
   logic signed [15:0] tan1_z;
   logic signed [15:0] tan2_x;
   logic signed [15:0] tan2_y;
   logic signed [15:0] tan2_z;
   logic               degenerate;

   modport source (output valid, output col0_x, output col0_y, output col0_z,
                   output tan1_x, output tan1_y, output tan1_z,
                   output tan2_x, output tan2_y, output tan2_z,
                   output degenerate, input ready);
   modport sink   (input valid, input col0_x, input col0_y, input col0_z,
                   input tan1_x, input tan1_y, input tan1_z,
                   input tan2_x, input tan2_y, input tan2_z,
                   input degenerate, output ready);
endinterface

FILE: design/contact_orthonormal_basis_core.sv
// Contact basis pipeline: normal in, normal plus two unit tangents out.
//
//   channel   direction  payload
//   req_ch    in         normal_x, normal_y, normal_z (Q2.14)
//   rsp_ch    out        col0_*, tan1_*, tan2_* (Q2.14), degenerate
//
// One transfer in per cycle while the output register is empty or taken; each
// Newton step of the 1/sqrt unit adds three multiplier stages to the pipe.
// All stages move together whenever the output register is empty or taken,
// so a stall freezes the whole pipe and nothing is dropped or repeated.
// Synchronous reset clears the stage valid bits only.
`timescale 1ns / 1ps

module contact_orthonormal_basis_core (
   input logic       clock,
   input logic       reset,
   cob_req_if.sink   req_ch,
   cob_rsp_if.source rsp_ch
);

   localparam int NI = cob_pkg::RSQRT_ITERS;

   logic adv;

   // Stage 1: capture, pick branch, square components
   logic             s1_v_ff;
   cob_pkg::ctx_type s1_ctx_ff, s1_ctx_in;
   logic [31:0]      s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;
   // Stage 2: sum of squares
   logic             s2_v_ff;
   cob_pkg::ctx_type s2_ctx_ff;
   logic [31:0]      s2_q_ff, s2_q_in;
   // Newton boundaries: index 0 is the normalizer output
   logic             it_v_ff   [0:NI];
   cob_pkg::ctx_type it_ctx_ff [0:NI];
   logic [31:0]      it_m_ff   [0:NI];
   logic [3:0]       it_sh_ff  [0:NI];
   logic [31:0]      it_y_ff   [0:NI];
   // Normalizer combinational
   logic [3:0]       nm_sh;
   logic [31:0]      nm_m;
   cob_pkg::ctx_type it_ctx_in;
   // Tangent 1 scale products
   logic                     f1_v_ff;
   cob_pkg::ctx_type         f1_ctx_ff;
   logic [5:0]               f1_d_ff;
   logic signed [48:0]       f1_p0_ff, f1_p1_ff, f1_p0_in, f1_p1_in;
   // Tangent 1 rounded
   logic                     f2_v_ff;
   cob_pkg::ctx_type         f2_ctx_ff;
   logic signed [15:0]       f2_t1x_ff, f2_t1y_ff, f2_t1z_ff;
   logic signed [15:0]       f2_t1x_in, f2_t1y_in, f2_t1z_in;
   // Cross product terms
   logic                     f3_v_ff;
   cob_pkg::ctx_type         f3_ctx_ff;
   logic signed [15:0]       f3_t1x_ff, f3_t1y_ff, f3_t1z_ff;
   logic signed [31:0]       f3_a_ff, f3_b_ff, f3_c_ff, f3_e_ff, f3_f_ff, f3_g_ff;
   // Output register
   logic                     out_v_ff;
   logic signed [15:0]       o_t2x_in, o_t2y_in, o_t2z_in;

   // Global advance: output register free or being drained
   assign adv          = !out_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1 context
   always_comb begin
      logic [16:0] ax, ay;
      ax = req_ch.normal_x[15] ? 17'(-18'(req_ch.normal_x)) : 17'(req_ch.normal_x);
      ay = req_ch.normal_y[15] ? 17'(-18'(req_ch.normal_y)) : 17'(req_ch.normal_y);
      s1_ctx_in.nx    = req_ch.normal_x;
      s1_ctx_in.ny    = req_ch.normal_y;
      s1_ctx_in.nz    = req_ch.normal_z;
      s1_ctx_in.use_x = ax > ay;
      s1_ctx_in.deg   = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctx_ff <= s1_ctx_in;
         s1_sqx_ff <= 32'(req_ch.normal_x * req_ch.normal_x);
         s1_sqy_ff <= 32'(req_ch.normal_y * req_ch.normal_y);
         s1_sqz_ff <= 32'(req_ch.normal_z * req_ch.normal_z);
      end
   end

   // Stage 2: q = nz^2 + na^2
   assign s2_q_in = s1_sqz_ff + (s1_ctx_ff.use_x ? s1_sqx_ff : s1_sqy_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctx_ff <= s1_ctx_ff;
         s2_q_ff   <= s2_q_in;
      end
   end

   // Stage 3: even left shift into [2^30, 2^32), seed lookup
   always_comb begin
      nm_sh = 4'd0;
      for (int k = 15; k >= 0; k--) begin
         if ((64'(s2_q_ff) << (2 * k)) >= cob_pkg::ONE_Q30) begin
            nm_sh = 4'(k);
         end
      end
      nm_m = s2_q_ff << {nm_sh, 1'b0};
   end

   // Zero sum of squares marks a degenerate normal
   always_comb begin
      it_ctx_in     = s2_ctx_ff;
      it_ctx_in.deg = (s2_q_ff == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         it_ctx_ff[0]     <= it_ctx_in;
         it_m_ff[0]       <= nm_m;
         it_sh_ff[0]      <= nm_sh;
         it_y_ff[0]       <= {2'b00, cob_pkg::SEED_Q16[nm_m[31:29]], 14'd0};
      end
   end

   // Newton steps, three multiplier stages each
   for (genvar k = 0; k < NI; k++) begin : g_newton
      logic             a_v_ff, b_v_ff;
      cob_pkg::ctx_type a_ctx_ff, b_ctx_ff;
      logic [31:0]      a_m_ff, a_y_ff, a_y2_ff, b_m_ff, b_y_ff, b_e_ff;
      logic [3:0]       a_sh_ff, b_sh_ff;
      logic [63:0]      a_p, b_p, c_p;
      logic [31:0]      b_t;

      assign a_p = it_y_ff[k] * it_y_ff[k];
      assign b_p = a_m_ff * a_y2_ff;
      assign b_t = 32'(b_p >> 30);
      assign c_p = b_y_ff * b_e_ff;

      always_ff @(posedge clock) begin
         if (reset) begin
            a_v_ff         <= 1'b0;
            b_v_ff         <= 1'b0;
            it_v_ff[k + 1] <= 1'b0;
         end else if (adv) begin
            a_v_ff         <= it_v_ff[k];
            b_v_ff         <= a_v_ff;
            it_v_ff[k + 1] <= b_v_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            // y2 = y*y
            a_ctx_ff <= it_ctx_ff[k];
            a_m_ff   <= it_m_ff[k];
            a_sh_ff  <= it_sh_ff[k];
            a_y_ff   <= it_y_ff[k];
            a_y2_ff  <= 32'(a_p >> 30);
            // e = 3 - m*y2, floored at zero
            b_ctx_ff <= a_ctx_ff;
            b_m_ff   <= a_m_ff;
            b_sh_ff  <= a_sh_ff;
            b_y_ff   <= a_y_ff;
            b_e_ff   <= (b_t >= cob_pkg::THREE_Q30) ? 32'd0 : cob_pkg::THREE_Q30 - b_t;
            // y = y*e/2
            it_ctx_ff[k + 1] <= b_ctx_ff;
            it_m_ff[k + 1]   <= b_m_ff;
            it_sh_ff[k + 1]  <= b_sh_ff;
            it_y_ff[k + 1]   <= 32'(c_p >> 31);
         end
      end
   end

   // Tangent 1 scale: c * y for the two live components
   always_comb begin
      logic signed [16:0] c0, c1;
      logic signed [31:0] ys;
      ys = $signed(it_y_ff[NI]);
      if (it_ctx_ff[NI].use_x) begin
         c0 = 17'(it_ctx_ff[NI].nz);
         c1 = -17'(it_ctx_ff[NI].nx);
      end else begin
         c0 = -17'(it_ctx_ff[NI].nz);
         c1 = 17'(it_ctx_ff[NI].ny);
      end
      f1_p0_in = c0 * ys;
      f1_p1_in = c1 * ys;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ctx_ff <= it_ctx_ff[NI];
         f1_d_ff   <= 6'(cob_pkg::D_BASE) - 6'(it_sh_ff[NI]);
         f1_p0_ff  <= f1_p0_in;
         f1_p1_ff  <= f1_p1_in;
      end
   end

   // Tangent 1 rounding and placement
   always_comb begin
      logic signed [15:0] r0, r1;
      r0 = cob_pkg::rsat(64'(f1_p0_ff), f1_d_ff);
      r1 = cob_pkg::rsat(64'(f1_p1_ff), f1_d_ff);
      f2_t1x_in = 16'sd0;
      f2_t1y_in = 16'sd0;
      f2_t1z_in = 16'sd0;
      if (!f1_ctx_ff.deg) begin
         if (f1_ctx_ff.use_x) f2_t1x_in = r0;
         else                 f2_t1y_in = r0;
         f2_t1z_in = r1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f2_ctx_ff <= f1_ctx_ff;
         f2_t1x_ff <= f2_t1x_in;
         f2_t1y_ff <= f2_t1y_in;
         f2_t1z_ff <= f2_t1z_in;
      end
   end

   // Cross product partial terms
   always_ff @(posedge clock) begin
      if (adv) begin
         f3_ctx_ff <= f2_ctx_ff;
         f3_t1x_ff <= f2_t1x_ff;
         f3_t1y_ff <= f2_t1y_ff;
         f3_t1z_ff <= f2_t1z_ff;
         f3_a_ff   <= f2_ctx_ff.ny * f2_t1z_ff;
         f3_b_ff   <= f2_ctx_ff.nz * f2_t1y_ff;
         f3_c_ff   <= f2_ctx_ff.nz * f2_t1x_ff;
         f3_e_ff   <= f2_ctx_ff.nx * f2_t1z_ff;
         f3_f_ff   <= f2_ctx_ff.nx * f2_t1y_ff;
         f3_g_ff   <= f2_ctx_ff.ny * f2_t1x_ff;
      end
   end

   // Tangent 2 differences, rounded
   assign o_t2x_in = cob_pkg::rsat(64'(33'(f3_a_ff) - 33'(f3_b_ff)),
                                   6'(cob_pkg::FRAC_BITS));
   assign o_t2y_in = cob_pkg::rsat(64'(33'(f3_c_ff) - 33'(f3_e_ff)),
                                   6'(cob_pkg::FRAC_BITS));
   assign o_t2z_in = cob_pkg::rsat(64'(33'(f3_f_ff) - 33'(f3_g_ff)),
                                   6'(cob_pkg::FRAC_BITS));

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ch.col0_x     <= f3_ctx_ff.nx;
         rsp_ch.col0_y     <= f3_ctx_ff.ny;
         rsp_ch.col0_z     <= f3_ctx_ff.nz;
         rsp_ch.tan1_x     <= f3_t1x_ff;
         rsp_ch.tan1_y     <= f3_t1y_ff;
         rsp_ch.tan1_z     <= f3_t1z_ff;
         rsp_ch.tan2_x     <= o_t2x_in;
         rsp_ch.tan2_y     <= o_t2y_in;
         rsp_ch.tan2_z     <= o_t2z_in;
         rsp_ch.degenerate <= f3_ctx_ff.deg;
      end
   end

   // Valid bits of the fixed stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         it_v_ff[0] <= 1'b0;
         f1_v_ff    <= 1'b0;
         f2_v_ff    <= 1'b0;
         f3_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
      end else if (adv) begin
         s1_v_ff    <= req_ch.valid;
         s2_v_ff    <= s1_v_ff;
         it_v_ff[0] <= s2_v_ff;
         f1_v_ff    <= it_v_ff[NI];
         f2_v_ff    <= f1_v_ff;
         f3_v_ff    <= f2_v_ff;
         out_v_ff   <= f3_v_ff;
      end
   end

   assign rsp_ch.valid = out_v_ff;

endmodule

FILE: tb/tb_channels.sv
// Testbench-side note: the channel interfaces come from the design folder; this file holds helpers.
`timescale 1ns / 1ps

package tb_basis_pkg;

   // One expected basis result
   typedef struct {
      logic signed [15:0] c0 [3];
      logic signed [15:0] t1 [3];
      logic signed [15:0] t2 [3];
      logic               deg;
   } basis_type;

   // Shift right rounding half away from zero, then clamp to 16 bits signed
   function automatic logic signed [15:0] round_clamp(longint v, int sh);
      longint unsigned mag;
      bit neg;
      neg = v < 0;
      mag = neg ? -v : v;
      if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
      if (!neg && mag > 32767) return 16'sh7FFF;
      if (neg && mag > 32768) return 16'sh8000;
      return neg ? 16'(-longint'(mag)) : 16'(mag);
   endfunction

   // Expected basis for one normal
   function automatic basis_type compute_basis(logic signed [15:0] x, logic signed [15:0] y,
                                               logic signed [15:0] z);
      basis_type b;
      longint nx, ny, nz, ax, ay, na, t1 [3];
      longint unsigned q, m, r, r2, t, e;
      bit use_x;
      int sh, d;
      longint unsigned seeds [8] = '{58617, 58617, 58617, 49541, 43691, 39520, 36353, 33843};
      nx = x; ny = y; nz = z;
      ax = nx < 0 ? -nx : nx;
      ay = ny < 0 ? -ny : ny;
      use_x = ax > ay;
      na = use_x ? nx : ny;
      q = nz * nz + na * na;
      b.c0 = '{x, y, z};
      t1 = '{0, 0, 0};
      b.t2 = '{0, 0, 0};
      if (q != 0) begin
         m = q; sh = 0;
         while (m < (64'd1 << 30)) begin m = m << 2; sh += 2; end
         r = seeds[(m >> 29) & 7] << 14;
         for (int i = 0; i < cob_pkg::RSQRT_ITERS; i++) begin
            r2 = (r * r) >> 30;
            t = (m * r2) >> 30;
            e = (t >= (64'd3 << 30)) ? 0 : (64'd3 << 30) - t;
            r = (r * e) >> 31;
         end
         d = 45 - cob_pkg::FRAC_BITS - sh / 2;
         if (use_x) begin
            t1[0] = round_clamp(nz * longint'(r), d);
            t1[2] = round_clamp(-nx * longint'(r), d);
         end else begin
            t1[1] = round_clamp(-nz * longint'(r), d);
            t1[2] = round_clamp(ny * longint'(r), d);
         end
         b.t2[0] = round_clamp(ny * t1[2] - nz * t1[1], cob_pkg::FRAC_BITS);
         b.t2[1] = round_clamp(nz * t1[0] - nx * t1[2], cob_pkg::FRAC_BITS);
         b.t2[2] = round_clamp(nx * t1[1] - ny * t1[0], cob_pkg::FRAC_BITS);
      end
      for (int i = 0; i < 3; i++) b.t1[i] = t1[i];
      b.deg = (q == 0);
      return b;
   endfunction

   // Scoreboard: holds expected bases in transfer order
   class basis_board;
      basis_type pending [$];
      int errors = 0;

      function void note_normal(logic signed [15:0] x, logic signed [15:0] y,
                                logic signed [15:0] z);
         pending.push_back(compute_basis(x, y, z));
      endfunction

      function void check_field(string name, longint e, longint a);
         if (e != a) begin
            $error("%s expected %0d actual %0d", name, e, a);
            errors++;
         end
      endfunction

      function void check_basis(basis_type got);
         basis_type ex;
         if (pending.size() == 0) begin
            $error("result with nothing pending");
            errors++;
            return;
         end
         ex = pending.pop_front();
         for (int i = 0; i < 3; i++) begin
            check_field($sformatf("col0[%0d]", i), ex.c0[i], got.c0[i]);
            check_field($sformatf("tan1[%0d]", i), ex.t1[i], got.t1[i]);
            check_field($sformatf("tan2[%0d]", i), ex.t2[i], got.t2[i]);
         end
         check_field("degenerate", ex.deg, got.deg);
      endfunction
   endclass
endpackage

FILE: tb/tb_top.sv
// Top-level testbench of the contact basis core: directed and random normals, random stalls.
`timescale 1ns / 1ps

module tb_top;

   logic clock = 0;
   logic reset = 1;
   cob_req_if req_ch ();
   cob_rsp_if rsp_ch ();
   tb_basis_pkg::basis_board board = new();
   bit sending_done = 0;
   bit hold_now = 0;

   contact_orthonormal_basis_core DUT (.clock(clock), .reset(reset),
                                       .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source));

   initial forever #4 clock = ~clock;

   // Gap length: mostly short, a few long
   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one normal and wait for its transfer
   task automatic send_normal(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
      req_ch.valid <= 1;
      req_ch.normal_x <= x;
      req_ch.normal_y <= y;
      req_ch.normal_z <= z;
      do @(posedge clock); while (!req_ch.ready);
      board.note_normal(x, y, z);
      @(negedge clock);
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         req_ch.valid <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Random normal: components all full-range, all tiny, or all within +-9459 each
   task automatic send_random(bit calm);
      logic signed [15:0] v [3];
      int k;
      k = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         case (k)
            0, 1: v[i] = 16'($urandom);
            2: v[i] = 16'($urandom_range(0, 8)) - 16'sd4;
            default: v[i] = $signed(16'($urandom_range(0, 18918))) - 16'sd9459;
         endcase
      end
      send_normal(v[0], v[1], v[2]);
      if (!calm) idle_cycles(gap_len());
   endtask

   // Stimulus
   initial begin
      logic signed [15:0] ex [10];
      req_ch.valid = 0;
      req_ch.normal_x = 0;
      req_ch.normal_y = 0;
      req_ch.normal_z = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(negedge clock);
      ex = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd16384, -16'sd16384, 16'sd1, -16'sd1,
             16'sd11585, -16'sd11585, 16'sd9459};
      // zero normal, axis normals, equal magnitudes, extremes
      send_normal(0, 0, 0);
      send_normal(16384, 0, 0);
      send_normal(0, 16384, 0);
      send_normal(0, 0, 16384);
      send_normal(-16384, 0, 0);
      send_normal(11585, 11585, 0);
      send_normal(-11585, 11585, 0);
      send_normal(9459, 9459, 9459);
      send_normal(16'sh8000, 16'sh8000, 16'sh8000);
      send_normal(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_normal(16'sh7FFF, 0, 16'sh8000);
      send_normal(1, 0, 0);
      send_normal(0, -1, 0);
      send_normal(0, 0, 1);
      send_normal(16'sh8000, 16'sh7FFF, 0);
      for (int i = 0; i < 8; i++) send_normal(ex[i], ex[i + 2], ex[9 - i]);
      // pressure phase: receiver holds off while inputs keep coming
      hold_now = 1;
      for (int i = 0; i < 60; i++) send_random(1);
      for (int i = 0; i < 1470; i++) send_random(i % 300 < 40);
      req_ch.valid <= 0;
      sending_done = 1;
   end

   // Receiver: random ready gaps, one long hold-off on request
   initial begin
      int n;
      tb_basis_pkg::basis_type got;
      rsp_ch.ready = 0;
      @(negedge reset);
      @(negedge clock);
      forever begin
         if (hold_now) begin
            hold_now = 0;
            rsp_ch.ready <= 0;
            repeat (80) @(negedge clock);
         end
         n = gap_len();
         if ($urandom_range(0, 3) == 0) n = 0;
         if (n > 0) begin
            rsp_ch.ready <= 0;
            repeat (n) @(negedge clock);
         end
         rsp_ch.ready <= 1;
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.c0 = '{rsp_ch.col0_x, rsp_ch.col0_y, rsp_ch.col0_z};
            got.t1 = '{rsp_ch.tan1_x, rsp_ch.tan1_y, rsp_ch.tan1_z};
            got.t2 = '{rsp_ch.tan2_x, rsp_ch.tan2_y, rsp_ch.tan2_z};
            got.deg = rsp_ch.degenerate;
            board.check_basis(got);
         end
         @(negedge clock);
      end
   end

   // End of run
   initial begin
      wait (sending_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog
   initial begin
      #4000000;
      $display("simulation failed");
      $finish;
   end
endmodule
